// ===== hw/rtl/path_option_payoff_evaluator_core_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef PATH_OPTION_PAYOFF_EVALUATOR_CORE_MACROS_SVH
`define PATH_OPTION_PAYOFF_EVALUATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/poe_pkg.sv =====
package poe_pkg;

   // Field widths.
   localparam int PRICE_W     = 32;
   localparam int WEIGHT_W    = 4;
   localparam int MAX_WEIGHT  = 15;
   localparam int SUM_W       = 48;
   localparam int COUNT_W     = 12;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_CNT_W   = $clog2(SUM_W);

   // Payoff kinds.
   localparam logic [KIND_W-1:0] KIND_EUROPEAN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ASIAN    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BARRIER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LOOKBACK = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_PAYOFF_KIND   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IS_PUT        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIKE        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BARRIER_PRICE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KNOCK_OUT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BARRIER_UP    = 3'd5;

   typedef struct packed {
      logic [PRICE_W-1:0]  price;
      logic [WEIGHT_W-1:0] average_weight;
      logic                last_sample;
   } req_type;

   typedef struct packed {
      logic [PRICE_W-1:0] payoff;
      logic               barrier_touched;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]  payoff_kind;
      logic               is_put;
      logic [PRICE_W-1:0] strike;
      logic [PRICE_W-1:0] barrier_price;
      logic               knock_out;
      logic               barrier_up;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic snap;
      logic div_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_divide;
   } sts_type;

endpackage

// ===== hw/rtl/poe_dpath.sv =====
module poe_dpath import poe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  cfg_type cfg,
   input  req_type req,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int PROD_W = PRICE_W + WEIGHT_W;

   logic [PRICE_W-1:0]  max_ff, max_in;
   logic [PRICE_W-1:0]  min_ff, min_in;
   logic                hit_ff, hit_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic [SUM_W-1:0]    quo_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [COUNT_W-1:0]  div_ff;
   logic                void_ff;
   logic                snap_hit_ff;
   rsp_type             rsp_ff;

   logic [WEIGHT_W-1:0] weight;
   logic                price_hit;
   logic [PROD_W-1:0]   product;
   logic [SUM_W:0]      sum_ext;
   logic [COUNT_W:0]    count_ext;
   logic [PRICE_W-1:0]  spot;
   logic                void_now;
   logic [COUNT_W:0]    shifted;
   logic [COUNT_W:0]    trial;
   logic [PRICE_W-1:0]  spot_final;
   logic [PRICE_W-1:0]  vanilla;

   // Running statistics updated by the current sample.
   always_comb begin
      weight    = (req.average_weight > WEIGHT_W'(MAX_WEIGHT)) ?
                  WEIGHT_W'(MAX_WEIGHT) : req.average_weight;
      max_in    = (req.price > max_ff) ? req.price : max_ff;
      min_in    = (req.price < min_ff) ? req.price : min_ff;
      price_hit = cfg.barrier_up ? (req.price >= cfg.barrier_price) :
                                   (req.price <= cfg.barrier_price);
      hit_in    = hit_ff | price_hit;
      product   = PROD_W'(req.price) * PROD_W'(weight);
      sum_ext   = {1'b0, sum_ff} + (SUM_W + 1)'(product);
      sum_in    = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      count_ext = {1'b0, count_ff} + (COUNT_W + 1)'(weight);
      count_in  = count_ext[COUNT_W] ? {COUNT_W{1'b1}} : count_ext[COUNT_W-1:0];
   end

   // Path summary taken when the last sample arrives.
   always_comb begin
      if (cfg.payoff_kind == KIND_LOOKBACK) begin
         spot = cfg.is_put ? min_in : max_in;
      end else begin
         spot = req.price;
      end
      void_now = ((cfg.payoff_kind == KIND_ASIAN) && (count_in == '0)) ||
                 ((cfg.payoff_kind == KIND_BARRIER) &&
                  (cfg.knock_out ? hit_in : !hit_in));
      sts.need_divide = (cfg.payoff_kind == KIND_ASIAN) && (count_in != '0);
   end

   // One restoring divide step, then clamp and the vanilla payoff.
   always_comb begin
      shifted    = {rem_ff, quo_ff[SUM_W-1]};
      trial      = shifted - {1'b0, div_ff};
      spot_final = (|quo_ff[SUM_W-1:PRICE_W]) ? {PRICE_W{1'b1}} : quo_ff[PRICE_W-1:0];
      if (cfg.is_put) begin
         vanilla = (cfg.strike > spot_final) ? (cfg.strike - spot_final) : '0;
      end else begin
         vanilla = (spot_final > cfg.strike) ? (spot_final - cfg.strike) : '0;
      end
   end

   // Accumulators clear after every path.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= '1;
         hit_ff   <= 1'b0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.take) begin
         if (cmd.snap) begin
            max_ff   <= '0;
            min_ff   <= '1;
            hit_ff   <= 1'b0;
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            max_ff   <= max_in;
            min_ff   <= min_in;
            hit_ff   <= hit_in;
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
      end
   end

   // Finishing unit: the quotient register holds either the spot price or the
   // dividend that turns into the average.
   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         quo_ff      <= sts.need_divide ? sum_in : SUM_W'(spot);
         rem_ff      <= '0;
         div_ff      <= count_in;
         void_ff     <= void_now;
         snap_hit_ff <= hit_in;
      end else if (cmd.div_step) begin
         if (!trial[COUNT_W]) begin
            rem_ff <= trial[COUNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[COUNT_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         rsp_ff.payoff          <= void_ff ? '0 : vanilla;
         rsp_ff.barrier_touched <= snap_hit_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== hw/rtl/poe_ctrl.sv =====
module poe_ctrl import poe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    req_last,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    fin_idle,
   output logic    rsp_valid
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_PAY  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // Commands follow the state and the input handshake.
   always_comb begin
      cmd.take     = req_fire;
      cmd.snap     = req_fire && req_last;
      cmd.div_step = (state_ff == S_DIV);
      cmd.load_out = (state_ff == S_PAY);
      fin_idle     = (state_ff == S_IDLE);
      rsp_valid    = (state_ff == S_HOLD);
   end

   // Next state: divide only for an average with a nonzero count.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (cmd.snap) begin
               state_in = sts.need_divide ? S_DIV : S_PAY;
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
               state_in = S_PAY;
            end
         end
         S_PAY: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/path_option_payoff_evaluator_core.sv =====
// Path payoff evaluator: path samples (unsigned Q16.16 prices) come in one word
// per cycle while no last sample is held back; samples that are not last are
// always taken. The last sample of a path ends the path: its word is taken only
// when the finishing unit is free. The payoff word for the european, barrier and
// lookback kinds is then formed in the payoff step and held until taken; for the
// asian average with a nonzero weight count the one-bit-per-cycle restoring divider
// of the weighted sum by the weight count runs before the payoff step. Samples of
// the next path keep streaming in while a payoff is being finished or waits to be
// taken; the next last sample waits until the previous payoff word has been taken.
`include "path_option_payoff_evaluator_core_macros.svh"

module path_option_payoff_evaluator_core import poe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic    fin_idle;
   logic    req_fire;

   // Configuration registers; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payoff_kind   <= KIND_EUROPEAN;
         cfg_ff.is_put        <= 1'b0;
         cfg_ff.strike        <= '0;
         cfg_ff.barrier_price <= '0;
         cfg_ff.knock_out     <= 1'b1;
         cfg_ff.barrier_up    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PAYOFF_KIND:   cfg_ff.payoff_kind   <= csr_wdata[KIND_W-1:0];
            REG_IS_PUT:        cfg_ff.is_put        <= csr_wdata[0];
            REG_STRIKE:        cfg_ff.strike        <= csr_wdata[PRICE_W-1:0];
            REG_BARRIER_PRICE: cfg_ff.barrier_price <= csr_wdata[PRICE_W-1:0];
            REG_KNOCK_OUT:     cfg_ff.knock_out     <= csr_wdata[0];
            REG_BARRIER_UP:    cfg_ff.barrier_up    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A last sample needs the finishing unit; other samples always go in.
   assign req_ready = fin_idle || !req_payload.last_sample;
   assign req_fire  = req_valid && req_ready;

   poe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_last  (req_payload.last_sample),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd),
      .fin_idle  (fin_idle),
      .rsp_valid (rsp_valid)
   );

   poe_dpath u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .cfg   (cfg_ff),
      .req   (req_payload),
      .sts   (sts),
      .rsp   (rsp_payload)
   );

   // Checks on the finishing handoff.
   `POE_ASSERT_NEXT(a_last_starts_finish, clock, reset, req_fire && req_payload.last_sample, !fin_idle, "last sample did not start the finishing unit")
   `POE_ASSERT_SAME(a_pending_blocks, clock, reset, rsp_valid, !fin_idle, "finishing unit idle while a payoff is pending")
   `POE_ASSERT_NEXT(a_taken_frees, clock, reset, rsp_valid && rsp_ready, fin_idle && !rsp_valid, "finishing unit not freed after the payoff was taken")

endmodule

// ===== test/payoff_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the payoff evaluator,
// predicts the payoff word of each path and compares it with what comes out.
module payoff_checker import poe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     outstanding
);

   // Register copy and the statistics of the path in progress.
   cfg_type            regs;
   logic [PRICE_W-1:0] path_max;
   logic [PRICE_W-1:0] path_min;
   logic               path_hit;
   logic [SUM_W-1:0]   path_sum;
   logic [COUNT_W-1:0] path_count;

   // Payoff words still owed by the block, oldest first.
   rsp_type due_payoffs[$];
   rsp_type want;

   function automatic logic [PRICE_W-1:0] intrinsic(input logic [PRICE_W-1:0] spot);
      if (regs.is_put) return (regs.strike > spot) ? regs.strike - spot : '0;
      return (spot > regs.strike) ? spot - regs.strike : '0;
   endfunction

   task automatic clear_path();
      path_max   = '0;
      path_min   = '1;
      path_hit   = 1'b0;
      path_sum   = '0;
      path_count = '0;
   endtask

   // Payoff of the finished path; the last price is passed in.
   function automatic logic [PRICE_W-1:0] path_payoff(input logic [PRICE_W-1:0] last_price);
      logic [SUM_W-1:0]   avg;
      logic [PRICE_W-1:0] pay;
      case (regs.payoff_kind)
         KIND_ASIAN: begin
            if (path_count == '0) begin
               pay = '0;
            end else begin
               avg = path_sum / {{(SUM_W-COUNT_W){1'b0}}, path_count};
               // A saturated count can push the average past the price range.
               pay = intrinsic((|avg[SUM_W-1:PRICE_W]) ? '1 : avg[PRICE_W-1:0]);
            end
         end
         KIND_BARRIER: begin
            pay = intrinsic(last_price);
            if (regs.knock_out ? path_hit : !path_hit) pay = '0;
         end
         KIND_LOOKBACK: pay = intrinsic(regs.is_put ? path_min : path_max);
         default: pay = intrinsic(last_price);
      endcase
      return pay;
   endfunction

   // Fold one accepted sample into the path and queue the payoff on the last one.
   task automatic absorb_sample(input req_type s);
      int                 w;
      logic [SUM_W:0]     sum_next;
      logic [COUNT_W:0]   count_next;
      logic [PRICE_W+3:0] add;
      w = s.average_weight;
      if (w > MAX_WEIGHT) w = MAX_WEIGHT;
      if (s.price > path_max) path_max = s.price;
      if (s.price < path_min) path_min = s.price;
      if (regs.barrier_up ? (s.price >= regs.barrier_price) : (s.price <= regs.barrier_price))
         path_hit = 1'b1;
      add = {4'b0, s.price} * (PRICE_W+4)'(w);
      // Sum and count both saturate instead of wrapping.
      sum_next = {1'b0, path_sum} + (SUM_W+1)'(add);
      path_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      count_next = {1'b0, path_count} + (COUNT_W+1)'(w);
      path_count = count_next[COUNT_W] ? '1 : count_next[COUNT_W-1:0];
      if (s.last_sample) begin
         want.payoff          = path_payoff(s.price);
         want.barrier_touched = path_hit;
         due_payoffs.insert(due_payoffs.size(), want);
         clear_path();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.payoff_kind   = KIND_EUROPEAN;
         regs.is_put        = 1'b0;
         regs.strike        = '0;
         regs.barrier_price = '0;
         regs.knock_out     = 1'b1;
         regs.barrier_up    = 1'b1;
         clear_path();
         due_payoffs.delete();
         mismatches = 0;
      end else begin
         // Results are matched before new samples so a fresh payoff never pairs early.
         if (rsp_valid && rsp_ready) begin
            if (due_payoffs.size() == 0) begin
               $display("%0t: result word with none expected: payoff %h barrier_touched %b",
                        $time, rsp_payload.payoff, rsp_payload.barrier_touched);
               mismatches++;
            end else begin
               want = due_payoffs.pop_front();
               if (rsp_payload.payoff !== want.payoff) begin
                  $display("%0t: payoff mismatch: expected %h actual %h",
                           $time, want.payoff, rsp_payload.payoff);
                  mismatches++;
               end
               if (rsp_payload.barrier_touched !== want.barrier_touched) begin
                  $display("%0t: barrier_touched mismatch: expected %b actual %b",
                           $time, want.barrier_touched, rsp_payload.barrier_touched);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) absorb_sample(req_payload);
         // Register writes count from the next sample; indexes outside the map are dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PAYOFF_KIND:   regs.payoff_kind   = csr_wdata[KIND_W-1:0];
               REG_IS_PUT:        regs.is_put        = csr_wdata[0];
               REG_STRIKE:        regs.strike        = csr_wdata[PRICE_W-1:0];
               REG_BARRIER_PRICE: regs.barrier_price = csr_wdata[PRICE_W-1:0];
               REG_KNOCK_OUT:     regs.knock_out     = csr_wdata[0];
               REG_BARRIER_UP:    regs.barrier_up    = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding = due_payoffs.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import poe_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int DRAIN_CYCLES    = 60;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_WORDS     = 70;
   localparam int HOLD_PHASE      = 3;
   localparam int LONG_PATH_LEN   = 300;

   // Register indexes that the block has no register for.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   // A few Q16.16 prices used by the directed paths.
   localparam logic [PRICE_W-1:0] P_0_5 = 32'h0000_8000;
   localparam logic [PRICE_W-1:0] P_1_0 = 32'h0001_0000;
   localparam logic [PRICE_W-1:0] P_1_2 = 32'h0001_3333;
   localparam logic [PRICE_W-1:0] P_1_5 = 32'h0001_8000;
   localparam logic [PRICE_W-1:0] P_1_8 = 32'h0001_CCCD;
   localparam logic [PRICE_W-1:0] P_2_0 = 32'h0002_0000;
   localparam logic [PRICE_W-1:0] P_2_5 = 32'h0002_8000;
   localparam logic [PRICE_W-1:0] P_3_0 = 32'h0003_0000;
   localparam logic [PRICE_W-1:0] P_5_0 = 32'h0005_0000;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int      mismatches;
   int      outstanding;
   int      req_gap_pct;
   int      rsp_stall_pct;
   int      cycle_count;
   bit      hold_rsp;
   cfg_type cur_cfg;

   path_option_payoff_evaluator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   payoff_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold when asked for.
   initial begin
      int burst;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            burst = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one sample word, possibly after a random gap. Called at a falling edge;
   // valid is left high so back-to-back words need no extra step.
   task automatic offer_word(input logic [PRICE_W-1:0] price,
                             input logic [WEIGHT_W-1:0] weight, input logic last);
      int gap;
      if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload.price          <= price;
      req_payload.average_weight <= weight;
      req_payload.last_sample    <= last;
      req_valid                  <= 1'b1;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes every register; unused upper bits carry noise to check the masking.
   task automatic program_regs(input cfg_type c);
      cur_cfg = c;
      write_reg(REG_PAYOFF_KIND, {30'($urandom()), c.payoff_kind});
      write_reg(REG_IS_PUT, {31'($urandom()), c.is_put});
      write_reg(REG_STRIKE, c.strike);
      write_reg(REG_BARRIER_PRICE, c.barrier_price);
      write_reg(REG_KNOCK_OUT, {31'($urandom()), c.knock_out});
      write_reg(REG_BARRIER_UP, {31'($urandom()), c.barrier_up});
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type make_cfg(input logic [KIND_W-1:0] kind, input logic put,
                                        input logic [PRICE_W-1:0] strike,
                                        input logic [PRICE_W-1:0] level,
                                        input logic ko, input logic up);
      cfg_type c;
      c.payoff_kind   = kind;
      c.is_put        = put;
      c.strike        = strike;
      c.barrier_price = level;
      c.knock_out     = ko;
      c.barrier_up    = up;
      return c;
   endfunction

   // Stop sending, let every payoff come back, then give the block time to go idle.
   task automatic settle();
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mix of extremes, prices around the strike and barrier, and uniform noise.
   function automatic logic [PRICE_W-1:0] pick_price();
      logic [PRICE_W-1:0] jitter;
      jitter = $urandom_range(0, 32'h0003_FFFF);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return cur_cfg.strike + jitter - 32'h0002_0000;
         4, 5: return cur_cfg.barrier_price + jitter - 32'h0002_0000;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int                 sent;
      int                 len;
      logic [PRICE_W-1:0] strike_pick;
      logic [PRICE_W-1:0] level_pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: european call, price extremes; writes to unmapped indexes first.
      write_reg(REG_SPARE_LO, $urandom());
      write_reg(REG_SPARE_HI, '1);
      program_regs(make_cfg(KIND_EUROPEAN, 1'b0, P_1_0, '1, 1'b1, 1'b1));
      offer_word('0, 4'd0, 1'b0);
      offer_word('1, 4'd15, 1'b1);
      offer_word('0, 4'd15, 1'b1);

      // Directed: asian call with an empty average, then a plain weighted average.
      settle();
      program_regs(make_cfg(KIND_ASIAN, 1'b0, '0, '0, 1'b0, 1'b0));
      offer_word(P_5_0, 4'd0, 1'b0);
      offer_word(P_2_0, 4'd0, 1'b1);
      offer_word(P_1_0, 4'd1, 1'b0);
      offer_word(P_3_0, 4'd2, 1'b0);
      offer_word(P_2_0, 4'd0, 1'b1);

      // Directed: down-and-in put, once hit and once not.
      settle();
      program_regs(make_cfg(KIND_BARRIER, 1'b1, P_2_0, P_1_0, 1'b0, 1'b0));
      offer_word(P_1_5, 4'd3, 1'b0);
      offer_word(P_0_5, 4'd1, 1'b0);
      offer_word(P_1_8, 4'd2, 1'b1);
      offer_word(P_1_5, 4'd0, 1'b0);
      offer_word(P_1_2, 4'd0, 1'b1);

      // Directed: up-and-out call, touching the barrier exactly, then clear of it.
      settle();
      program_regs(make_cfg(KIND_BARRIER, 1'b0, P_1_0, P_3_0, 1'b1, 1'b1));
      offer_word(P_2_0, 4'd0, 1'b0);
      offer_word(P_3_0, 4'd0, 1'b0);
      offer_word(P_2_5, 4'd0, 1'b1);
      offer_word(P_2_5, 4'd0, 1'b1);

      // Directed: lookback put on the minimum, then lookback call on the maximum.
      settle();
      program_regs(make_cfg(KIND_LOOKBACK, 1'b1, '1, '0, 1'b1, 1'b1));
      offer_word(32'h8000_0000, 4'd7, 1'b0);
      offer_word(32'h0000_0001, 4'd8, 1'b0);
      offer_word(32'h4000_0000, 4'd9, 1'b1);
      settle();
      program_regs(make_cfg(KIND_LOOKBACK, 1'b0, '0, '1, 1'b1, 1'b0));
      offer_word('1, 4'd1, 1'b0);
      offer_word('0, 4'd0, 1'b1);

      // A long asian path near the top price: the weight count saturates and the
      // average overflows the price range.
      settle();
      req_gap_pct   = 5;
      rsp_stall_pct = 10;
      program_regs(make_cfg(KIND_ASIAN, 1'b0, 32'h8000_0000, '1, 1'b1, 1'b1));
      len = LONG_PATH_LEN;
      for (int j = 0; j < len; j++)
         offer_word({16'hFFFF, 16'($urandom())}, WEIGHT_W'(MAX_WEIGHT), j == len - 1);

      // Random phases, each with its own register setting and idling mix.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == 0) begin
            strike_pick = '0;
            level_pick  = '0;
         end else if (p == 1) begin
            strike_pick = '1;
            level_pick  = '1;
         end else begin
            strike_pick = $urandom();
            level_pick  = $urandom();
         end
         if (p == RANDOM_PHASES - 1 || p == HOLD_PHASE) begin
            req_gap_pct   = 0;
            rsp_stall_pct = (p == HOLD_PHASE) ? 10 : 0;
         end else begin
            req_gap_pct   = 15 * $urandom_range(0, 2);
            rsp_stall_pct = 15 * $urandom_range(0, 2);
         end
         program_regs(make_cfg((p < 8) ? KIND_W'(p % 4) : KIND_W'($urandom()),
                               (p < 8) ? 1'((p / 4) % 2) : 1'($urandom()),
                               strike_pick, level_pick, 1'($urandom()), 1'($urandom())));
         // The long hold with short paths fills the block and backs up the samples.
         if (p == HOLD_PHASE) hold_rsp = 1'b1;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if (p == HOLD_PHASE)
               len = $urandom_range(1, 3);
            else if ($urandom_range(0, 7) == 0)
               len = $urandom_range(13, 40);
            else
               len = $urandom_range(1, 12);
            for (int j = 0; j < len; j++)
               offer_word(pick_price(), WEIGHT_W'($urandom_range(0, MAX_WEIGHT)),
                          j == len - 1);
            sent += len;
         end
      end

      // Drain and give the verdict.
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
